FILE: src/dirty_range_coalescer_unit_defines.svh
// Assertion macros shared by the checker of the range coalescer.
// No dependencies; included by the checker file only.
`ifndef DIRTY_RANGE_COALESCER_UNIT_DEFINES_SVH
`define DIRTY_RANGE_COALESCER_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drc check failed");

// Next-cycle implication, masked during reset.
`define DRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drc check failed");

`endif

FILE: src/drc_pkg.sv
// Types, codes and sizes of the dirty range coalescer.
// Used by the top level, drc_ctrl, drc_dp and the bench; no dependencies.
`default_nettype none
package drc_pkg;
    localparam int MAX_RANGES = 16;
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    localparam logic [15:0] EXT_LO   = 16'hA000;
    localparam logic [15:0] WORK_LO  = 16'hC000;
    localparam logic [15:0] BANK_LO  = 16'hD000;
    localparam logic [15:0] BANK_HI  = 16'hE000;
    localparam logic [16:0] ADDR_TOP = 17'h10000;
    localparam logic [17:0] WORK_SIZE = 18'h08000;
    localparam logic [7:0]  BANK_MAX = 8'd7;

    localparam logic CFG_EXT_SIZE = 1'b0;
    localparam logic CFG_WORK_RAM = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        SP_EXT  = 2'd0,
        SP_WORK = 2'd1,
        SP_BANK = 2'd2
    } t_space;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MRG_RD,
        S_MRG_EV,
        S_RD_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  sp;
        logic [7:0]  bk;
        logic [15:0] start;
        logic [16:0] len;
    } t_entry;

    typedef struct packed {
        logic    load;
        logic    rd_scan;
        logic    rd_merge;
        logic    rd_idx;
        logic    scan_next;
        logic    hit;
        logic    merge_step;
        logic    final_wr;
        logic    append;
        logic    clear;
        logic    set_stat;
        t_status stat;
        logic    take_entry;
        logic    deliver;
    } t_cmd;

    typedef struct packed {
        t_op     op;
        t_status chk;
        logic    touch;
        logic    scan_end;
        logic    merge_end;
        logic    full;
        logic    idx_ok;
        logic    out_free;
    } t_sts;
endpackage
`default_nettype wire

FILE: src/dirty_range_coalescer_unit.sv
// Top level of the dirty range coalescer: stream ports, APB registers, ctrl and datapath.
// Depends on drc_pkg, drc_ctrl, drc_dp.
//
//  channel  | kind         | payload
//  s_axis   | word in      | tuser: operation; tdata: space, bank, address, width, entry_index
//  m_axis   | word out     | tdata: status, range_count, entry fields
//  apb      | registers    | 0x0 ext_ram_size, 0x4 work_ram_present
//
// Write word: a check, then a read and an evaluate step per stored range scanned or merged;
// read word: a check and one table read; clear and rejected words: the check only.
// Reset (synchronous, i_rst_n low) empties the table; no clearing pass.
// A finished word waits in the output register; the next input word is taken meanwhile,
// and the sequencer only holds at its end if the previous result is still not taken.
`default_nettype none
module dirty_range_coalescer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
    // [1:0] space, [9:2] bank, [25:10] address, [41:26] width, [45:42] entry_index
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [6:2] range_count, [8:7] entry_space, [16:9] entry_bank,
    // [32:17] entry_address, [49:33] entry_width
    output logic [55:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import drc_pkg::*;

    logic [17:0] r_ext_size;
    logic        r_work_present;
    t_cmd        cmd;
    t_sts        sts;
    logic [1:0]  o_status;
    logic [4:0]  o_count;
    logic [1:0]  o_esp;
    logic [7:0]  o_ebk;
    logic [15:0] o_eaddr;
    logic [16:0] o_ewidth;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_size <= '0;
            r_work_present <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                CFG_EXT_SIZE: r_ext_size <= pwdata[17:0];
                CFG_WORK_RAM: r_work_present <= pwdata[0];
                default: r_ext_size <= r_ext_size;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_EXT_SIZE: prdata = {14'd0, r_ext_size};
            CFG_WORK_RAM: prdata = {31'd0, r_work_present};
            default: prdata = '0;
        endcase
    end

    drc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    drc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (s_axis_tuser),
        .i_space         (s_axis_tdata[1:0]),
        .i_bank          (s_axis_tdata[9:2]),
        .i_address       (s_axis_tdata[25:10]),
        .i_width         (s_axis_tdata[41:26]),
        .i_entry_index   (s_axis_tdata[45:42]),
        .i_ext_size      (r_ext_size),
        .i_work_present  (r_work_present),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (o_status),
        .o_range_count   (o_count),
        .o_entry_space   (o_esp),
        .o_entry_bank    (o_ebk),
        .o_entry_address (o_eaddr),
        .o_entry_width   (o_ewidth)
    );

    assign m_axis_tdata = {6'd0, o_ewidth, o_eaddr, o_ebk, o_esp, o_count, o_status};
endmodule
`default_nettype wire

FILE: src/drc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module drc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/drc_ctrl.sv
// Sequencer of the coalescer: checks, scans, merges and delivers one word at a time.
// Depends on drc_pkg.
`default_nettype none
module drc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire drc_pkg::t_sts i_sts,
    output drc_pkg::t_cmd      o_cmd
);
    import drc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CHECK;
            S_CHECK: begin
                unique case (i_sts.op)
                    OP_WRITE: n_state = (i_sts.chk == ST_OK) ? S_SCAN_RD : S_DONE;
                    OP_READ:  n_state = i_sts.idx_ok ? S_RD_EV : S_DONE;
                    default:  n_state = S_DONE;
                endcase
            end
            S_SCAN_RD: n_state = i_sts.scan_end ? S_DONE : S_SCAN_EV;
            S_SCAN_EV: n_state = i_sts.touch ? S_MRG_RD : S_SCAN_RD;
            S_MRG_RD:  n_state = i_sts.merge_end ? S_DONE : S_MRG_EV;
            S_MRG_EV:  n_state = S_MRG_RD;
            S_RD_EV:   n_state = S_DONE;
            S_DONE:    if (i_sts.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.stat = ST_OK;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_CHECK: begin
                unique case (i_sts.op)
                    OP_WRITE: begin
                        if (i_sts.chk != ST_OK) begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat = i_sts.chk;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.idx_ok) begin
                            o_cmd.rd_idx = 1'b1;
                        end else begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat = ST_RANGE;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.set_stat = 1'b1;
                    end
                    default: begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat = ST_INVALID;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.set_stat = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.stat = ST_FULL;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            S_SCAN_EV: begin
                if (i_sts.touch) begin
                    o_cmd.hit = 1'b1;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_MRG_RD: begin
                if (i_sts.merge_end) begin
                    o_cmd.final_wr = 1'b1;
                    o_cmd.set_stat = 1'b1;
                end else begin
                    o_cmd.rd_merge = 1'b1;
                end
            end
            S_MRG_EV: o_cmd.merge_step = 1'b1;
            S_RD_EV: begin
                o_cmd.take_entry = 1'b1;
                o_cmd.set_stat = 1'b1;
            end
            S_DONE: o_cmd.deliver = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/drc_dp.sv
// Datapath of the coalescer: item registers, bounds check, range table, merge unit, result.
// Depends on drc_pkg and drc_ram.
`default_nettype none
module drc_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire drc_pkg::t_cmd i_cmd,
    output drc_pkg::t_sts      o_sts,
    input  wire logic [1:0]    i_op,
    input  wire logic [1:0]    i_space,
    input  wire logic [7:0]    i_bank,
    input  wire logic [15:0]   i_address,
    input  wire logic [15:0]   i_width,
    input  wire logic [3:0]    i_entry_index,
    input  wire logic [17:0]   i_ext_size,
    input  wire logic          i_work_present,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [4:0]         o_range_count,
    output logic [1:0]         o_entry_space,
    output logic [7:0]         o_entry_bank,
    output logic [15:0]        o_entry_address,
    output logic [16:0]        o_entry_width
);
    import drc_pkg::*;

    logic [1:0]       r_op, r_sp;
    logic [7:0]       r_bk;
    logic [15:0]      r_addr, r_w;
    logic [3:0]       r_idx;
    logic [CNT_W-1:0] r_cnt, r_i, r_j, r_wp;
    logic [IDX_W-1:0] r_slot;
    logic [15:0]      r_ms;
    logic [16:0]      r_ml;
    t_status          r_stat;
    t_entry           r_ent;
    logic             r_ovalid;

    t_entry           rd_ent, wr_ent;
    logic             we;
    logic [IDX_W-1:0] waddr, raddr;

    drc_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_RANGES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_ent),
        .i_raddr (raddr),
        .o_rdata (rd_ent)
    );

    // bounds check of a write word
    logic        map_ok;
    logic [20:0] off;
    logic [17:0] size;
    logic [21:0] off_end;
    logic [16:0] addr_end;
    t_status     chk;

    always_comb begin
        map_ok = 1'b0;
        off = '0;
        size = '0;
        case (r_sp)
            SP_EXT: begin
                map_ok = (r_addr >= EXT_LO) && (r_addr < WORK_LO);
                off = {r_bk, 13'(r_addr - EXT_LO)};
                size = i_ext_size;
            end
            SP_WORK: begin
                map_ok = (r_bk == 8'd0) && (r_addr >= WORK_LO) && (r_addr < BANK_LO);
                off = 21'(12'(r_addr - WORK_LO));
                size = i_work_present ? WORK_SIZE : '0;
            end
            SP_BANK: begin
                map_ok = (r_bk != 8'd0) && (r_bk <= BANK_MAX)
                      && (r_addr >= BANK_LO) && (r_addr < BANK_HI);
                off = 21'({r_bk[2:0], 12'(r_addr - BANK_LO)});
                size = i_work_present ? WORK_SIZE : '0;
            end
            default: map_ok = 1'b0;
        endcase
        off_end = {1'b0, off} + {6'd0, r_w};
        addr_end = {1'b0, r_addr} + {1'b0, r_w};
        if (r_w == 16'd0) begin
            chk = ST_INVALID;
        end else if (!map_ok || off_end > {4'd0, size} || addr_end > ADDR_TOP) begin
            chk = ST_RANGE;
        end else begin
            chk = ST_OK;
        end
    end

    // touch test and growth of the held range against the word read from the table
    logic [17:0] m_end, e_end, g_end;
    logic [15:0] g_start;
    logic        touch;

    always_comb begin
        m_end = {2'd0, r_ms} + {1'b0, r_ml};
        e_end = {2'd0, rd_ent.start} + {1'b0, rd_ent.len};
        touch = (rd_ent.sp == r_sp) && (rd_ent.bk == r_bk)
             && ({2'd0, rd_ent.start} <= m_end) && ({2'd0, r_ms} <= e_end);
        g_start = (rd_ent.start < r_ms) ? rd_ent.start : r_ms;
        g_end = (e_end > m_end) ? e_end : m_end;
    end

    always_comb begin
        we = 1'b0;
        waddr = IDX_W'(r_wp);
        wr_ent = rd_ent;
        if (i_cmd.append) begin
            we = 1'b1;
            waddr = IDX_W'(r_cnt);
            wr_ent = '{sp: r_sp, bk: r_bk, start: r_addr, len: {1'b0, r_w}};
        end else if (i_cmd.final_wr) begin
            we = 1'b1;
            waddr = r_slot;
            wr_ent = '{sp: r_sp, bk: r_bk, start: r_ms, len: r_ml};
        end else if (i_cmd.merge_step && !touch) begin
            we = 1'b1;
        end
        if (i_cmd.rd_idx) begin
            raddr = IDX_W'(r_idx);
        end else if (i_cmd.rd_merge) begin
            raddr = IDX_W'(r_j);
        end else begin
            raddr = IDX_W'(r_i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_sp <= i_space;
            r_bk <= i_bank;
            r_addr <= i_address;
            r_w <= i_width;
            r_idx <= i_entry_index;
            r_i <= '0;
            r_ms <= i_address;
            r_ml <= {1'b0, i_width};
            r_ent <= '0;
        end
        if (i_cmd.scan_next) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.hit || (i_cmd.merge_step && touch)) begin
            r_ms <= g_start;
            r_ml <= 17'(g_end - {2'd0, g_start});
        end
        if (i_cmd.hit) begin
            r_slot <= IDX_W'(r_i);
            r_j <= r_i + 1'b1;
            r_wp <= r_i + 1'b1;
        end
        if (i_cmd.merge_step) begin
            r_j <= r_j + 1'b1;
            if (!touch) begin
                r_wp <= r_wp + 1'b1;
            end
        end
        if (i_cmd.set_stat) begin
            r_stat <= i_cmd.stat;
        end
        if (i_cmd.take_entry) begin
            r_ent <= rd_ent;
        end
        if (i_cmd.deliver) begin
            o_status <= r_stat;
            o_range_count <= 5'(r_cnt);
            o_entry_space <= r_ent.sp;
            o_entry_bank <= r_ent.bk;
            o_entry_address <= r_ent.start;
            o_entry_width <= r_ent.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end else if (i_cmd.append) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.final_wr) begin
                r_cnt <= r_wp;
            end
            if (i_cmd.deliver) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;

    always_comb begin
        o_sts.op = t_op'(r_op);
        o_sts.chk = chk;
        o_sts.touch = touch;
        o_sts.scan_end = (r_i == r_cnt);
        o_sts.merge_end = (r_j == r_cnt);
        o_sts.full = (r_cnt == CNT_W'(MAX_RANGES));
        o_sts.idx_ok = (CNT_W'(r_idx) < r_cnt) && ({28'd0, r_idx} < MAX_RANGES);
        o_sts.out_free = !r_ovalid || i_out_ready;
    end
endmodule
`default_nettype wire

FILE: src/drc_checker.sv
// Port-level checks of the coalescer, bound to the top level.
// Depends on dirty_range_coalescer_unit_defines.svh.
`default_nettype none
`include "dirty_range_coalescer_unit_defines.svh"
module drc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    // one word in the sequencer at a time: the input side closes right after a word is taken
    `DRC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // count never exceeds the table depth
    `DRC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[6:2] <= 5'd16)
    // a failed word carries no entry
    `DRC_ASSERT_NOW(a_fail_no_entry, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0), m_axis_tdata[49:7] == 43'd0)
    // a stalled result holds
    `DRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire

bind dirty_range_coalescer_unit drc_checker u_drc_checker (.*);

FILE: bench/dirty_range_coalescer_unit_test.sv
// Self-checking bench for dirty_range_coalescer_unit: directed, config and random words,
// with random source and sink stalls, checked against a built-in range table tracker.
// Depends on drc_pkg and dirty_range_coalescer_unit.
`timescale 1ns / 100ps
`default_nettype none
module dirty_range_coalescer_unit_test;
    import drc_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] SP_OTHER   = 2'd3;
    localparam logic [2:0] ADDR_EXT   = 3'd0;
    localparam logic [2:0] ADDR_WORK  = 3'd4;
    localparam int         STALL_LIMIT = 5000;
    localparam int         LONG_HOLD   = 300;

    // listed from the top bit down, matching m_axis_tdata[49:0]
    typedef struct packed {
        logic [16:0] len;
        logic [15:0] addr;
        logic [7:0]  bk;
        logic [1:0]  sp;
        logic [4:0]  count;
        logic [1:0]  status;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dirty_range_coalescer_unit u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // tracker copy of the table and registers
    logic [1:0]  trk_sp    [MAX_RANGES];
    logic [7:0]  trk_bk    [MAX_RANGES];
    int unsigned trk_start [MAX_RANGES];
    int unsigned trk_len   [MAX_RANGES];
    int unsigned trk_count;
    int unsigned ext_size;
    bit          work_on;

    t_result     pending_results[$];
    int          errors;
    int          next_gap;
    int          idle_cycles;
    bit          cfg_busy;
    bit          hold_req;
    int          hold_left;
    int          sink_wait;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic bit touches(int k, logic [1:0] sp, logic [7:0] bk,
                                   int unsigned st, int unsigned ln);
        if (trk_sp[k] != sp || trk_bk[k] != bk) return 0;
        return trk_start[k] <= st + ln && st <= trk_start[k] + trk_len[k];
    endfunction

    function automatic void grow(int k, int unsigned st, int unsigned ln);
        int unsigned s, e1, e2;
        s  = trk_start[k] < st ? trk_start[k] : st;
        e1 = trk_start[k] + trk_len[k];
        e2 = st + ln;
        trk_start[k] = s & 32'hFFFF;
        trk_len[k]   = ((e1 > e2 ? e1 : e2) - s) & 32'h1FFFF;
    endfunction

    function automatic logic [1:0] record_range(logic [1:0] sp, logic [7:0] bk,
                                                int unsigned st, int unsigned ln);
        int j;
        for (int i = 0; i < trk_count; i++) begin
            if (!touches(i, sp, bk, st, ln)) continue;
            grow(i, st, ln);
            j = i + 1;
            while (j < trk_count) begin
                if (!touches(i, trk_sp[j], trk_bk[j], trk_start[j], trk_len[j])) begin
                    j++;
                    continue;
                end
                grow(i, trk_start[j], trk_len[j]);
                for (int m = j; m + 1 < trk_count; m++) begin
                    trk_sp[m]    = trk_sp[m + 1];
                    trk_bk[m]    = trk_bk[m + 1];
                    trk_start[m] = trk_start[m + 1];
                    trk_len[m]   = trk_len[m + 1];
                end
                trk_count--;
            end
            return ST_OK;
        end
        if (trk_count >= MAX_RANGES) return ST_FULL;
        trk_sp[trk_count]    = sp;
        trk_bk[trk_count]    = bk;
        trk_start[trk_count] = st;
        trk_len[trk_count]   = ln;
        trk_count++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] track_write(logic [1:0] sp, logic [7:0] bk,
                                               int unsigned addr, int unsigned w);
        int unsigned off, size;
        if (w == 0) return ST_INVALID;
        case (sp)
            SP_EXT: begin
                if (addr < EXT_LO || addr >= WORK_LO) return ST_RANGE;
                off  = bk * 32'h2000 + (addr - EXT_LO);
                size = ext_size;
            end
            SP_WORK: begin
                if (bk != 0 || addr < WORK_LO || addr >= BANK_LO) return ST_RANGE;
                off  = addr - WORK_LO;
                size = work_on ? 32'h8000 : 0;
            end
            SP_BANK: begin
                if (bk == 0 || bk > BANK_MAX || addr < BANK_LO || addr >= BANK_HI)
                    return ST_RANGE;
                off  = bk * 32'h1000 + (addr - BANK_LO);
                size = work_on ? 32'h8000 : 0;
            end
            default: return ST_RANGE;
        endcase
        if (off > size || w > size - off || addr + w > ADDR_TOP) return ST_RANGE;
        return record_range(sp, bk, addr, w);
    endfunction

    function automatic t_result track_word(logic [1:0] op, logic [1:0] sp, logic [7:0] bk,
                                           logic [15:0] addr, logic [15:0] w,
                                           logic [3:0] idx);
        t_result r;
        r = '0;
        case (op)
            OP_WRITE: r.status = track_write(sp, bk, addr, w);
            OP_READ: begin
                if (idx < trk_count) begin
                    r.status = ST_OK;
                    r.sp     = trk_sp[idx];
                    r.bk     = trk_bk[idx];
                    r.addr   = trk_start[idx][15:0];
                    r.len    = trk_len[idx][16:0];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                trk_count = 0;
                r.status  = ST_OK;
            end
            default: r.status = ST_INVALID;
        endcase
        r.count = trk_count[4:0];
        return r;
    endfunction

    task automatic send_word(logic [1:0] op, logic [1:0] sp, logic [7:0] bk,
                             logic [15:0] addr, logic [15:0] w, logic [3:0] idx);
        if (next_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (next_gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, idx, w, addr, bk, sp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(track_word(op, sp, bk, addr, w, idx));
        next_gap = $urandom_range(0, 5);
    endtask

    // stop sending, let every result arrive, then allow for a word still in flight
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        next_gap = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        cfg_busy = 1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (a == ADDR_EXT) ext_size = d & 32'h3FFFF;
        else work_on = d[0];
        cfg_busy = 0;
    endtask

    task automatic set_config(int unsigned size, bit work);
        drain();
        apb_write(ADDR_EXT, size);
        apb_write(ADDR_WORK, {31'd0, work});
    endtask

    task automatic test_rejects;
        send_word(OP_WRITE, SP_EXT, 8'd0, 16'hA000, 16'd0, 4'd0);       // zero width
        send_word(OP_WRITE, SP_OTHER, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_word(OP_WRITE, SP_EXT, 8'd0, 16'hA000, 16'd1, 4'd0);       // no ext RAM yet
        send_word(OP_READ, SP_EXT, 8'd0, 16'd0, 16'd0, 4'd0);           // read past count
        send_word(OP_UNUSED, SP_EXT, 8'd0, 16'd0, 16'd0, 4'd0);
    endtask

    task automatic test_bounds;
        set_config(32'h20000, 1'b1);
        send_word(OP_WRITE, SP_EXT, 8'd15, 16'hBFFF, 16'd1, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'hFF, 16'hA000, 16'd1, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'd0, 16'hA000, 16'hFFFF, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'd0, 16'h9FFF, 16'd1, 4'd0);
        send_word(OP_WRITE, SP_WORK, 8'd0, 16'hC000, 16'h1000, 4'd0);
        send_word(OP_WRITE, SP_WORK, 8'd1, 16'hC000, 16'd1, 4'd0);
        send_word(OP_WRITE, SP_BANK, 8'd7, 16'hD000, 16'h1000, 4'd0);
        send_word(OP_WRITE, SP_BANK, 8'd8, 16'hD000, 16'd1, 4'd0);
        send_word(OP_WRITE, SP_BANK, 8'd0, 16'hDFFF, 16'd1, 4'd0);
        for (int i = 0; i < 4; i++) send_word(OP_READ, 2'd0, 8'd0, 16'd0, 16'd0, 4'(i));
        send_word(OP_CLEAR, 2'd0, 8'd0, 16'd0, 16'd0, 4'd0);
    endtask

    // gapped ranges in bank 2 beside one in bank 3, then two words that bridge the bank-2 gaps
    task automatic test_cascade;
        send_word(OP_WRITE, SP_EXT, 8'd2, 16'hA040, 16'h10, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'd3, 16'hA010, 16'h10, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'd2, 16'hA000, 16'h10, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'd2, 16'hA020, 16'h10, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'd2, 16'hA010, 16'h10, 4'd0);
        send_word(OP_WRITE, SP_EXT, 8'd2, 16'hA030, 16'h10, 4'd0);
        for (int i = 0; i < 3; i++) send_word(OP_READ, 2'd0, 8'd0, 16'd0, 16'd0, 4'(i));
    endtask

    task automatic test_full_table;
        send_word(OP_CLEAR, 2'd0, 8'd0, 16'd0, 16'd0, 4'd0);
        for (int i = 0; i <= MAX_RANGES; i++)
            send_word(OP_WRITE, SP_EXT, 8'd1, 16'hA000 + 16'(i * 4), 16'd2, 4'd0);
        send_word(OP_READ, 2'd0, 8'd0, 16'd0, 16'd0, 4'hF);
    endtask

    task automatic send_random;
        logic [1:0]  op, sp;
        logic [7:0]  bk;
        logic [15:0] addr, w;
        int          pick;
        pick = $urandom_range(0, 99);
        op   = pick < 72 ? OP_WRITE : pick < 92 ? OP_READ : pick < 96 ? OP_CLEAR : OP_UNUSED;
        sp   = $urandom_range(0, 9) == 0 ? 2'($urandom) : 2'($urandom_range(0, 2));
        bk   = 8'($urandom_range(0, 3));
        addr = {4'h0, 12'($urandom_range(0, 255))};
        w    = 16'($urandom_range(1, 48));
        case (sp)
            SP_EXT:  addr = addr + 16'hA000 + 16'($urandom_range(0, 1) * 16'h1000);
            SP_WORK: begin
                bk   = 8'd0;
                addr = addr + WORK_LO;
            end
            default: begin
                bk   = 8'($urandom_range(1, 7));
                addr = addr + BANK_LO;
            end
        endcase
        if ($urandom_range(0, 19) == 0) bk = 8'($urandom);
        if ($urandom_range(0, 19) == 0) addr = 16'($urandom);
        if ($urandom_range(0, 19) == 0) w = 16'($urandom);
        if ($urandom_range(0, 49) == 0) w = 16'd0;
        send_word(op, sp, bk, addr, w, 4'($urandom));
    endtask

    task automatic test_random;
        set_config(32'h20000, 1'b1);
        repeat (500) send_random();
        set_config(32'd0, 1'b0);
        repeat (300) send_random();
        set_config($urandom_range(0, 32'h20000), 1'b1);
        repeat (600) send_random();
        set_config(32'h2000, 1'b0);
        repeat (300) send_random();
        set_config(32'h3FFFF, 1'b1);
        repeat (300) send_random();
    endtask

    task automatic test_backpressure;
        hold_req = 1;
        repeat (12) send_random();
    endtask

    // sink: random stalls, one long hold on request, and the result check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result got, want;
            got = m_axis_tdata[49:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.count != want.count) begin
                    $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
                    errors++;
                end
                if (got.sp != want.sp || got.bk != want.bk) begin
                    $display("%0t: space/bank exp %0d/%0d got %0d/%0d", $time,
                             want.sp, want.bk, got.sp, got.bk);
                    errors++;
                end
                if (got.addr != want.addr || got.len != want.len) begin
                    $display("%0t: addr/len exp %h/%h got %h/%h", $time,
                             want.addr, want.len, got.addr, got.len);
                    errors++;
                end
            end
            sink_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 5);
        end
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_busy
            || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        errors        = 0;
        next_gap      = 0;
        idle_cycles   = 0;
        cfg_busy      = 0;
        hold_req      = 0;
        hold_left     = 0;
        sink_wait     = 0;
        trk_count     = 0;
        ext_size      = 0;
        work_on       = 1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rejects();
        test_bounds();
        test_cascade();
        test_full_table();
        test_random();
        test_backpressure();
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
